/* hw/rtl/grs_pkg.sv */
// Shared types, constants and helper functions for the glyph row styler.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package grs_pkg;

  localparam int MAX_FONT_WIDTH  = 32;
  localparam int MAX_FONT_HEIGHT = 32;
  localparam int WIDTH_CAP = (MAX_FONT_WIDTH < 32) ? MAX_FONT_WIDTH : 32;

  localparam int ROW_W     = 32;
  localparam int IDX_W     = 5;
  localparam int FLAG_W    = 7;
  localparam int CFG_W     = 6;
  localparam int CFG_IDX_W = 2;

  // style flag bit positions
  localparam int FLG_BOLD   = 0;
  localparam int FLG_ITALIC = 1;
  localparam int FLG_STRIKE = 2;
  localparam int FLG_TOP    = 3;
  localparam int FLG_UNDER  = 4;
  localparam int FLG_LEFT   = 5;
  localparam int FLG_RIGHT  = 6;

  localparam logic [ROW_W-1:0] ROW_MSB = {1'b1, {(ROW_W-1){1'b0}}};

  localparam logic [CFG_W-1:0] RST_FONT_WIDTH  = 6'd8;
  localparam logic [CFG_W-1:0] RST_FONT_HEIGHT = 6'd16;
  localparam logic [1:0]       RST_ORIENTATION = 2'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FONT_WIDTH  = 2'd0,
    REG_FONT_HEIGHT = 2'd1,
    REG_ORIENTATION = 2'd2
  } cfg_reg_t;

  // effective configuration, already clamped
  typedef struct packed {
    logic [CFG_W-1:0] width;
    logic [CFG_W-1:0] height;
    logic [1:0]       orient;
    logic [ROW_W-1:0] mask;
  } cfg_t;

  typedef struct packed {
    logic [ROW_W-1:0]  glyph_row;
    logic [IDX_W-1:0]  row_index;
    logic [FLAG_W-1:0] style_flags;
    logic [ROW_W-1:0]  overlay_row;
  } item_t;

  function automatic logic [CFG_W-1:0] clamp_width(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) r = 6'd1;
    else if ({1'b0, v} > 7'(WIDTH_CAP)) r = 6'(WIDTH_CAP);
    else r = v;
    return r;
  endfunction

  function automatic logic [CFG_W-1:0] clamp_height(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] r;
    if (v == '0) r = 6'd1;
    else if ({1'b0, v} > 7'(MAX_FONT_HEIGHT)) r = 6'(MAX_FONT_HEIGHT);
    else r = v;
    return r;
  endfunction

  // whole bytes covering the glyph width, rounded up to a byte, from the left
  function automatic logic [ROW_W-1:0] row_mask(input logic [CFG_W-1:0] w);
    logic [CFG_W:0]   sum;
    logic [2:0]       nbytes;
    logic [ROW_W-1:0] m;
    sum    = {1'b0, w} + 7'd7;
    nbytes = sum[5:3];
    case (nbytes)
      3'd1:    m = 32'hFF00_0000;
      3'd2:    m = 32'hFFFF_0000;
      3'd3:    m = 32'hFFFF_FF00;
      default: m = 32'hFFFF_FFFF;
    endcase
    return m;
  endfunction

  // move top/right/under/left flags around the cycle by r quarter turns
  function automatic logic [FLAG_W-1:0] rotate_sides(input logic [FLAG_W-1:0] f,
                                                     input logic [1:0] r);
    logic [3:0]        s;
    logic [7:0]        t;
    logic [3:0]        sr;
    logic [FLAG_W-1:0] nf;
    s  = {f[FLG_LEFT], f[FLG_UNDER], f[FLG_RIGHT], f[FLG_TOP]};
    t  = {s, s} << r;
    sr = t[7:4];
    nf = f;
    nf[FLG_TOP]   = sr[0];
    nf[FLG_RIGHT] = sr[1];
    nf[FLG_UNDER] = sr[2];
    nf[FLG_LEFT]  = sr[3];
    return nf;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/grs_ifs.sv */
// Valid/ready channel interfaces for glyph rows in and styled rows out.
// Depends on grs_pkg for field widths.
`default_nettype none

interface grs_row_in_if
  import grs_pkg::*;
  ;
  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  glyph_row;
  logic [IDX_W-1:0]  row_index;
  logic [FLAG_W-1:0] style_flags;
  logic [ROW_W-1:0]  overlay_row;

  modport source (output valid, glyph_row, row_index, style_flags, overlay_row,
                  input ready);
  modport sink   (input valid, glyph_row, row_index, style_flags, overlay_row,
                  output ready);
endinterface

interface grs_row_out_if
  import grs_pkg::*;
  ;
  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] styled_row;

  modport source (output valid, styled_row, input ready);
  modport sink   (input valid, styled_row, output ready);
endinterface

`default_nettype wire

/* hw/rtl/grs_cfg.sv */
// Configuration registers, stored in clamped form along with the row mask.
// Depends on grs_pkg.
`default_nettype none

module grs_cfg
  import grs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  output cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width  <= RST_FONT_WIDTH;
      cfg.height <= RST_FONT_HEIGHT;
      cfg.orient <= RST_ORIENTATION;
      cfg.mask   <= row_mask(RST_FONT_WIDTH);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FONT_WIDTH: begin
          cfg.width <= clamp_width(cfg_wdata);
          cfg.mask  <= row_mask(clamp_width(cfg_wdata));
        end
        REG_FONT_HEIGHT: begin
          cfg.height <= clamp_height(cfg_wdata);
        end
        REG_ORIENTATION: begin
          cfg.orient <= cfg_wdata[1:0];
        end
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/grs_in_stage.sv */
// Input register: captures one glyph row item per transfer.
// Depends on grs_pkg and grs_row_in_if.
`default_nettype none

module grs_in_stage
  import grs_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  grs_row_in_if.sink  row_in,
  input  wire logic   drain,
  output logic        valid,
  output item_t       item
);

  // accept when empty or when the held item moves on this cycle
  assign row_in.ready = !valid || drain;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (row_in.ready) begin
      valid <= row_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (row_in.valid && row_in.ready) begin
      item.glyph_row   <= row_in.glyph_row;
      item.row_index   <= row_in.row_index;
      item.style_flags <= row_in.style_flags;
      item.overlay_row <= row_in.overlay_row;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/grs_style.sv */
// Styling datapath: bold, italic, overlay, strikeout and the four side lines.
// Depends on grs_pkg.
`default_nettype none

module grs_style
  import grs_pkg::*;
(
  input  cfg_t              cfg,
  input  item_t             item,
  output logic [ROW_W-1:0]  styled_row
);

  logic [ROW_W-1:0]  row0, ovl, r1, r2, r3, r4, r5, r6, r7;
  logic [FLAG_W-1:0] f;
  logic [CFG_W-1:0]  idx, half, last;

  always_comb begin
    row0 = item.glyph_row & cfg.mask;
    ovl  = item.overlay_row & cfg.mask;
    f    = rotate_sides(item.style_flags, cfg.orient);
    idx  = {1'b0, item.row_index};
    half = cfg.height >> 1;
    last = cfg.height - 6'd1;

    r1 = f[FLG_BOLD] ? ((row0 | (row0 >> 1)) & cfg.mask) : row0;
    r2 = (f[FLG_ITALIC] && (idx < half)) ? (r1 >> 1) : r1;
    r3 = r2 ^ ovl;

    r4 = r3;
    if (f[FLG_STRIKE]) begin
      // sideways screens strike through a column instead of a row
      if (cfg.orient[0]) r4 = r3 | (ROW_MSB >> (cfg.width >> 1));
      else if (idx == half) r4 = cfg.mask;
    end

    r5 = (f[FLG_TOP] && (idx == '0)) ? cfg.mask : r4;
    r6 = (f[FLG_UNDER] && (idx == last)) ? cfg.mask : r5;
    r7 = r6;
    if (f[FLG_LEFT])  r7 = r7 | ROW_MSB;
    if (f[FLG_RIGHT]) r7 = r7 | (ROW_MSB >> (cfg.width - 6'd1));

    // rows past the glyph come out blank
    styled_row = (idx >= cfg.height) ? '0 : (r7 & cfg.mask);
  end

endmodule

`default_nettype wire

/* hw/rtl/grs_out_stage.sv */
// Result register driving the output channel; holds a row until transferred.
// Depends on grs_pkg and grs_row_out_if.
`default_nettype none

module grs_out_stage
  import grs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              load_valid,
  input  wire logic [ROW_W-1:0]  load_row,
  grs_row_out_if.source          row_out,
  output logic                   advance
);

  assign advance = !row_out.valid || row_out.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_out.valid <= 1'b0;
    end else if (advance) begin
      row_out.valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      row_out.styled_row <= load_row;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/glyph_row_styler.sv */
// Glyph row styler: one styled row out for each glyph row in.
// A row passes two registers: the input register, then the result register.
// Throughput: one row per cycle while the output is ready; a stalled result also holds
// a full input register, while an empty input register can still take a row.
// Reset (synchronous, active high) empties both stages and sets width 8, height 16,
// orientation 0.
`default_nettype none

module glyph_row_styler
  import grs_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_wdata,
  grs_row_in_if.sink                row_in,
  grs_row_out_if.source             row_out
);

  cfg_t             cfg;
  item_t            item;
  logic             item_valid;
  logic             advance;
  logic [ROW_W-1:0] row_next;

  grs_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  grs_in_stage u_in (
    .clk    (clk),
    .rst    (rst),
    .row_in (row_in),
    .drain  (advance),
    .valid  (item_valid),
    .item   (item)
  );

  grs_style u_style (
    .cfg        (cfg),
    .item       (item),
    .styled_row (row_next)
  );

  grs_out_stage u_out (
    .clk        (clk),
    .rst        (rst),
    .load_valid (item_valid),
    .load_row   (row_next),
    .row_out    (row_out),
    .advance    (advance)
  );

endmodule

`default_nettype wire

/* hw/rtl/grs_checker.sv */
// Port-level checks on the glyph row styler, attached by bind.
// Depends on grs_pkg and the top level glyph_row_styler.
`default_nettype none

module grs_checker
  import grs_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [ROW_W-1:0] styled_row
);

  logic [1:0] cnt;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_xfer && !out_xfer) begin
      cnt <= cnt + 2'd1;
    end else if (out_xfer && !in_xfer) begin
      cnt <= cnt - 2'd1;
    end
  end

  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

  a_occupancy: assert property (@(posedge clk) disable iff (rst) cnt <= 2'd2)
    else $error("more than two items in flight");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> cnt != 2'd0)
    else $error("result shown with no item in flight");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back pressure");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(styled_row)))
    else $error("stalled result changed");

endmodule

bind glyph_row_styler grs_checker u_grs_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (row_in.valid),
  .in_ready   (row_in.ready),
  .out_valid  (row_out.valid),
  .out_ready  (row_out.ready),
  .styled_row (row_out.styled_row)
);

`default_nettype wire
